FILE: hw/rtl/positional_sequence_store_defines.svh
// Assertion macros used by the positional sequence store controller.
`ifndef POSITIONAL_SEQUENCE_STORE_DEFINES_SVH
`define POSITIONAL_SEQUENCE_STORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pss_pkg.sv
// Package: codes, widths and controller/datapath types of the sequence store.
`timescale 1ns / 1ps
package pss_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W  = 2;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic step;     // emit one dump word and rotate the cell row
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic dump_start;  // input word is a dump of a non-empty store
        logic dump_last;   // cell 0 holds the final entry of the dump
    } t_sts;

endpackage

FILE: hw/rtl/pss_dp.sv
// Datapath: shifting cell row, entry count, dump index and output registers.
`timescale 1ns / 1ps
module pss_dp
    import pss_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_element,
    output logic [POS_W-1:0]        o_index,
    output logic [LEN_W-1:0]        o_length,
    output logic                    o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [IW-1:0]                r_dump_idx;

    logic [ST_W-1:0]         r_status;
    logic signed [VAL_W-1:0] r_element;
    logic [POS_W-1:0]        r_index;
    logic [LEN_W-1:0]        r_length;
    logic                    r_last;

    logic [POS_W-1:0]             w_cnt8;
    logic                         w_full;
    logic                         w_ins_ok;
    logic                         w_del_ok;
    logic                         w_load_reply;
    logic [ST_W-1:0]              w_status;
    logic [POS_W-1:0]             w_index;
    logic signed [DATA_WIDTH-1:0] w_store_val;
    logic [CW-1:0]                w_cnt_m1;

    assign w_cnt8      = POS_W'(r_count);
    assign w_full      = (r_count >= CW'(CAPACITY));
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_store_val = DATA_WIDTH'(i_value);

    assign w_ins_ok = i_cmd.accept && (i_operation == OP_INSERT) && !w_full
                      && (i_position <= w_cnt8);
    assign w_del_ok = i_cmd.accept && (i_operation == OP_DELETE)
                      && (i_position < w_cnt8);

    assign o_sts.dump_start = (i_operation == OP_DUMP) && (r_count != '0);
    assign o_sts.dump_last  = ((CW'(r_dump_idx) + CW'(1)) == r_count);

    assign w_load_reply = i_cmd.accept && !o_sts.dump_start;

    always_comb begin
        w_index = i_position;
        unique case (i_operation)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (i_position > w_cnt8) begin
                    w_status = ST_RANGE;
                end else begin
                    w_status = ST_OK;
                end
            end
            OP_DELETE: begin
                w_status = (i_position < w_cnt8) ? ST_OK : ST_RANGE;
            end
            OP_DUMP: begin
                w_status = ST_EMPTY;
                w_index  = '0;
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (w_del_ok) begin
            n_count = w_cnt_m1;
        end
    end

    // Each cell picks from itself, its lower neighbor, its upper neighbor or
    // the new value; a dump rotates the live part of the row through cell 0.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] w_below;
        logic signed [DATA_WIDTH-1:0] w_above;

        if (g == 0) begin : g_bot
            assign w_below = r_cell[0];
        end else begin : g_low
            assign w_below = r_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_top
            assign w_above = r_cell[0];
        end else begin : g_high
            assign w_above = r_cell[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ins_ok) begin
                if (POS_W'(g) == i_position) begin
                    r_cell[g] <= w_store_val;
                end else if (POS_W'(g) > i_position) begin
                    r_cell[g] <= w_below;
                end
            end else if (w_del_ok) begin
                if (POS_W'(g) >= i_position) begin
                    r_cell[g] <= w_above;
                end
            end else if (i_cmd.step) begin
                r_cell[g] <= (CW'(g) == w_cnt_m1) ? r_cell[0] : w_above;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dump_idx <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_dump_idx <= '0;
            end else if (i_cmd.step) begin
                r_dump_idx <= o_sts.dump_last ? '0 : r_dump_idx + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_reply) begin
            r_status  <= w_status;
            r_element <= '0;
            r_index   <= w_index;
            r_length  <= LEN_W'(n_count);
            r_last    <= 1'b1;
        end else if (i_cmd.step) begin
            r_status  <= ST_OK;
            r_element <= VAL_W'(r_cell[0]);
            r_index   <= POS_W'(r_dump_idx);
            r_length  <= LEN_W'(r_count);
            r_last    <= o_sts.dump_last;
        end
    end

    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_index   = r_index;
    assign o_length  = r_length;
    assign o_last    = r_last;

endmodule

FILE: hw/rtl/pss_ctrl.sv
// Controller: handshake and idle/dump sequencing of the sequence store.
`timescale 1ns / 1ps
`include "positional_sequence_store_defines.svh"
module pss_ctrl
    import pss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic w_slot_free;

    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && w_slot_free;
    assign o_cmd.accept = i_in_valid && o_in_ready;
    assign o_cmd.step   = (r_state == S_DUMP) && w_slot_free;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_sts.dump_start) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (o_cmd.step && i_sts.dump_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((o_cmd.accept && !i_sts.dump_start) || o_cmd.step) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PSS_ASSERT_IMP(a_no_accept_in_dump, r_state == S_DUMP, !o_in_ready, "input taken during dump")
    `PSS_ASSERT_NXT(a_dump_enter, o_cmd.accept && i_sts.dump_start, (r_state == S_DUMP) && !r_out_valid, "dump start mishandled")
    `PSS_ASSERT_NXT(a_dump_exit, o_cmd.step && i_sts.dump_last, (r_state == S_IDLE) && r_out_valid, "dump end mishandled")

endmodule

FILE: hw/rtl/positional_sequence_store.sv
// Insert, delete and rejected words give one result word the cycle after acceptance.
// Dump of n entries: n result words on consecutive free output cycles, the first once the
// controller is in its dump state; cell 0 is read as the live part of the cell row rotates once per word.
// Throughput: one insert or delete per cycle while i_out_ready is high; a dump stalls the input.
// Reset (i_rst_n low, synchronous): empties the store and drops any pending result word;
// cell contents stay as they were and are never read before being written again.
`timescale 1ns / 1ps
module positional_sequence_store
    import pss_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Request channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    // Result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [ST_W-1:0]         o_status,
    output logic signed [VAL_W-1:0] o_element,
    output logic [POS_W-1:0]        o_index,
    output logic [LEN_W-1:0]        o_length,
    output logic                    o_last
);

    // Commands from the sequencer into the cell row, status flags back.
    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: owns both handshakes, holds the input for the whole dump.
    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: shift the cells up on insert, down on delete, rotate on dump,
    // and hold the result word in its output register until taken.
    pss_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_index     (o_index),
        .o_length    (o_length),
        .o_last      (o_last)
    );

endmodule

FILE: tb/sv/positional_sequence_store_check.sv
// Scoreboard for the positional sequence store: mirrors the list and checks each result word.
`timescale 1ns / 1ps
module positional_sequence_store_check
    import pss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [ST_W-1:0]         i_status,
    input  logic signed [VAL_W-1:0] i_element,
    input  logic [POS_W-1:0]        i_index,
    input  logic [LEN_W-1:0]        i_length,
    input  logic                    i_last,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_words_checked
);

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] element;
        logic [POS_W-1:0]        index;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } t_result_word;

    logic signed [VAL_W-1:0] cells[$];
    t_result_word            result_words[$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
    end

    function automatic t_result_word make_word(input logic [ST_W-1:0] status,
                                               input logic signed [VAL_W-1:0] element,
                                               input logic [POS_W-1:0] index,
                                               input logic last);
        t_result_word w;
        w.status  = status;
        w.element = element;
        w.index   = index;
        w.length  = LEN_W'(cells.size());
        w.last    = last;
        return w;
    endfunction

    // Update the mirrored list for one request word and queue the result words it causes.
    task automatic apply_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                 input logic signed [VAL_W-1:0] val);
        int n;
        n = cells.size();
        case (op)
            OP_INSERT: begin
                if (n >= CAPACITY) begin
                    result_words.push_back(make_word(ST_FULL, '0, pos, 1'b1));
                end else if (int'(pos) > n) begin
                    result_words.push_back(make_word(ST_RANGE, '0, pos, 1'b1));
                end else begin
                    cells.insert(int'(pos), val);
                    result_words.push_back(make_word(ST_OK, '0, pos, 1'b1));
                end
            end
            OP_DELETE: begin
                if (int'(pos) >= n) begin
                    result_words.push_back(make_word(ST_RANGE, '0, pos, 1'b1));
                end else begin
                    cells.delete(int'(pos));
                    result_words.push_back(make_word(ST_OK, '0, pos, 1'b1));
                end
            end
            OP_DUMP: begin
                if (n == 0) begin
                    result_words.push_back(make_word(ST_EMPTY, '0, '0, 1'b1));
                end else begin
                    for (int k = 0; k < n; k++) begin
                        result_words.push_back(make_word(ST_OK, cells[k], POS_W'(k),
                                                         k == n - 1));
                    end
                end
            end
            default: begin
                result_words.push_back(make_word(ST_RANGE, '0, pos, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: result %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result_word want;
        if (!i_rst_n) begin
            cells.delete();
            result_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                apply_request(i_operation, i_position, i_value);
            end
            if (i_out_valid && i_out_ready) begin
                if (result_words.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result word with none expected, expected nothing, got %0h %0h %0h %0h %0h",
                             $time, i_status, i_element, i_index, i_length, i_last);
                end else begin
                    want = result_words.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(i_status));
                    check_field("element", want.element, i_element);
                    check_field("index", VAL_W'(want.index), VAL_W'(i_index));
                    check_field("length", VAL_W'(want.length), VAL_W'(i_length));
                    check_field("last", VAL_W'(want.last), VAL_W'(i_last));
                    o_words_checked++;
                end
            end
        end
        o_pending <= result_words.size();
    end

endmodule

FILE: tb/sv/positional_sequence_store_tb.sv
// Testbench top for the positional sequence store: clock, reset, request and result traffic.
`timescale 1ns / 1ps
module positional_sequence_store_tb;
    import pss_pkg::*;

    localparam int              CAPACITY     = CAPACITY_DEF;
    // Operation code the block does not define; it must be answered as out of range.
    localparam logic [OP_W-1:0] OP_RESERVED  = 2'd3;
    localparam int              LIMIT_CYCLES = 200000;
    localparam int              HOLD_CYCLES  = 90;
    localparam int              TAIL_CYCLES  = 8;
    localparam int              STEADY_WORDS = 40;
    localparam int              RANDOM_UNTIL = 150;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation = OP_INSERT;
    logic [POS_W-1:0]        i_position  = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [ST_W-1:0]         o_status;
    logic signed [VAL_W-1:0] o_element;
    logic [POS_W-1:0]        o_index;
    logic [LEN_W-1:0]        o_length;
    logic                    o_last;

    int          fail_count;
    int          pending;
    int          words_checked;
    // Entries the store holds once every word sent so far is applied; shapes positions only.
    int          fill         = 0;
    int          words_sent   = 0;
    int          op_count [4] = '{0, 0, 0, 0};
    bit          steady       = 1'b0;   // no idling on either side while set
    bit          hold_request = 1'b0;   // ask the result side for one long stall
    int unsigned cycle_count  = 0;

    always #1 i_clk = ~i_clk;

    positional_sequence_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_element   (o_element),
        .o_index     (o_index),
        .o_length    (o_length),
        .o_last      (o_last)
    );

    positional_sequence_store_check #(
        .CAPACITY (CAPACITY)
    ) list_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_element       (o_element),
        .i_index         (o_index),
        .i_length        (o_length),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // Abort a hung run and report it as failed.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: drop ready at random about 6 percent of the time, hold it low for one long
    // stretch on request so the block backs up, and keep it high while steady is set.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= 6);
            end
        end
    end

    // Favor the corner values of the data path, otherwise any 32-bit pattern.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one request word and hold it until accepted; unless steady is set, sometimes idle first.
    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        if (!steady && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        do @(posedge i_clk); while (!o_in_ready);
        // Advance the fill level only for words the store actually applies.
        if (op == OP_INSERT && fill < CAPACITY && int'(pos) <= fill) begin
            fill++;
        end else if (op == OP_DELETE && int'(pos) < fill) begin
            fill--;
        end
        op_count[op]++;
        words_sent++;
    endtask

    // Drop valid and hold off until every expected result word has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly in-range inserts and deletes, with dumps and some malformed words mixed in.
    task automatic send_random_word();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            send_word(OP_INSERT, POS_W'($urandom_range(0, fill)), pick_value());
        end else if (roll < 72) begin
            send_word(OP_DELETE, POS_W'(fill == 0 ? 0 : $urandom_range(0, fill - 1)),
                      pick_value());
        end else if (roll < 80) begin
            send_word(OP_DUMP, POS_W'($urandom), pick_value());
        end else if (roll < 90) begin
            send_word(roll[0] ? OP_INSERT : OP_DELETE, POS_W'($urandom_range(0, 255)),
                      pick_value());
        end else begin
            send_word(OP_RESERVED, POS_W'($urandom_range(0, 255)), pick_value());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on an empty store: empty dump, delete with nothing stored,
        // insert past the length.
        send_word(OP_DUMP, 8'd0, '0);
        send_word(OP_DELETE, 8'd0, '0);
        send_word(OP_INSERT, 8'd1, 32'h1234_5678);
        // Build a short list: append, insert at the front, at the end and in the middle.
        send_word(OP_INSERT, 8'd0, 32'h7FFF_FFFF);
        send_word(OP_INSERT, 8'd0, 32'h8000_0000);
        send_word(OP_INSERT, 8'd2, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 8'd1, 32'h0000_0000);
        // Rejected words: far position, reserved operation at both position extremes.
        send_word(OP_INSERT, 8'hFF, 32'h5A5A_A5A5);
        send_word(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_RESERVED, 8'h00, 32'h0000_0000);
        // Dump ignores position and value.
        send_word(OP_DUMP, 8'hFF, 32'hFFFF_FFFF);
        // Delete past and at the length, then the last and the first entry.
        send_word(OP_DELETE, 8'hFF, '0);
        send_word(OP_DELETE, 8'd4, '0);
        send_word(OP_DELETE, 8'd3, '0);
        send_word(OP_DELETE, 8'd0, '0);
        send_word(OP_DUMP, 8'd0, '0);
        // Sender pause: let every pending result word drain.
        wait_drained();

        // Fill the store while the result side stalls, so the block backs up and
        // holds off the request side.
        hold_request = 1'b1;
        while (fill < CAPACITY) begin
            send_word(OP_INSERT, POS_W'($urandom_range(0, fill)), pick_value());
        end
        // Full store: full is reported ahead of a bad position, and at the length too.
        send_word(OP_INSERT, POS_W'($urandom_range(CAPACITY + 1, 255)), pick_value());
        send_word(OP_INSERT, POS_W'(CAPACITY), pick_value());
        send_word(OP_DUMP, 8'd0, '0);
        send_word(OP_DELETE, POS_W'(CAPACITY - 1), '0);
        send_word(OP_INSERT, POS_W'(CAPACITY - 1), pick_value());
        send_word(OP_DUMP, 8'd0, '0);
        wait_drained();

        // A stretch with no idling on either side, then random traffic with idling.
        steady = 1'b1;
        repeat (STEADY_WORDS) send_random_word();
        steady = 1'b0;
        while (words_sent < RANDOM_UNTIL) begin
            send_random_word();
        end

        // Empty the store entry by entry and close with an empty dump.
        while (fill > 0) begin
            send_word(OP_DELETE, POS_W'($urandom_range(0, fill - 1)), pick_value());
        end
        send_word(OP_DUMP, 8'd0, '0);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d request words: %0d insert, %0d delete, %0d dump, %0d reserved",
                 words_sent, op_count[OP_INSERT], op_count[OP_DELETE], op_count[OP_DUMP],
                 op_count[OP_RESERVED]);
        $display("%0d result words checked, %0d mismatches, %0d still expected",
                 words_checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
